@@ hdl/key_combo_table_sorter_core_defines.svh @@
// Assertion macros used by the sorter core design file.
`ifndef KEY_COMBO_TABLE_SORTER_CORE_DEFINES_SVH
`define KEY_COMBO_TABLE_SORTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property, disabled in reset.
`define KCTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked property, also checked during reset.
`define KCTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KCTS_ASSERT(label, prop, msg)
`define KCTS_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ hdl/kcts_pkg.sv @@
`default_nettype none
package kcts_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned IdxW       = 7;
  localparam int unsigned CfgIdxW    = 2;

  // Operation codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_SORT  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SHIFT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CTRL  = 2'd2;

  localparam logic [CodeW-1:0] ShiftReset = 8'd42;
  localparam logic [CodeW-1:0] AltReset   = 8'd56;
  localparam logic [CodeW-1:0] CtrlReset  = 8'd29;

  // Entry classes in sort order
  localparam logic [1:0] CLS_COMBO  = 2'd0;
  localparam logic [1:0] CLS_SINGLE = 2'd1;
  localparam logic [1:0] CLS_MOD    = 2'd2;
  localparam logic [1:0] CLS_EMPTY  = 2'd3;

  typedef struct packed {
    logic [CodeW-1:0] scan1;
    logic [CodeW-1:0] scan2;
    logic [CodeW-1:0] row1;
    logic [CodeW-1:0] col1;
    logic [CodeW-1:0] row2;
    logic [CodeW-1:0] col2;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [1:0]       cls;
    logic [CodeW-1:0] scan1;
    logic [CodeW-1:0] row1;
    logic [CodeW-1:0] col1;
    logic [CodeW-1:0] row2;
    logic [CodeW-1:0] col2;
  } key_t;

  typedef struct packed {
    logic [CodeW-1:0] shift_code;
    logic [CodeW-1:0] alt_code;
    logic [CodeW-1:0] ctrl_code;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/kcts_if.sv @@
`default_nettype none
// Command word channel
interface kcts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] entry_index;
  logic [7:0] in_scan_first;
  logic [7:0] in_scan_second;
  logic [7:0] in_row_first;
  logic [7:0] in_col_first;
  logic [7:0] in_row_second;
  logic [7:0] in_col_second;

  modport source (output valid, func, entry_index, in_scan_first, in_scan_second,
                  in_row_first, in_col_first, in_row_second, in_col_second,
                  input ready);
  modport sink (input valid, func, entry_index, in_scan_first, in_scan_second,
                in_row_first, in_col_first, in_row_second, in_col_second,
                output ready);
endinterface

// Result word channel
interface kcts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_scan_first;
  logic [7:0] out_scan_second;
  logic [7:0] out_row_first;
  logic [7:0] out_col_first;
  logic [7:0] out_row_second;
  logic [7:0] out_col_second;
  logic       op_done;

  modport source (output valid, out_scan_first, out_scan_second, out_row_first,
                  out_col_first, out_row_second, out_col_second, op_done,
                  input ready);
  modport sink (input valid, out_scan_first, out_scan_second, out_row_first,
                out_col_first, out_row_second, out_col_second, op_done,
                output ready);
endinterface
`default_nettype wire

@@ hdl/kcts_ram.sv @@
`default_nettype none
module kcts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/kcts_keygen.sv @@
`default_nettype none
// Composite sort key: class, then scan1, row1, col1, row2, col2.
module kcts_keygen (
  input  wire kcts_pkg::entry_t entry_i,
  input  wire kcts_pkg::cfg_t   cfg_i,
  output      kcts_pkg::key_t   key_o
);
  logic [1:0] cls;

  always_comb begin
    if (entry_i.scan1 == '0 && entry_i.scan2 == '0) begin
      cls = kcts_pkg::CLS_EMPTY;
    end else if (entry_i.scan2 != '0) begin
      cls = kcts_pkg::CLS_COMBO;
    end else if (entry_i.scan1 == cfg_i.shift_code || entry_i.scan1 == cfg_i.alt_code ||
                 entry_i.scan1 == cfg_i.ctrl_code) begin
      cls = kcts_pkg::CLS_MOD;
    end else begin
      cls = kcts_pkg::CLS_SINGLE;
    end
  end

  assign key_o = '{cls: cls, scan1: entry_i.scan1, row1: entry_i.row1,
                   col1: entry_i.col1, row2: entry_i.row2, col2: entry_i.col2};
endmodule
`default_nettype wire

@@ hdl/key_combo_table_sorter_core.sv @@
// Channel  | Dir | Payload
// in_w     | in  | func, entry_index, six entry fields
// out_w    | out | six entry fields, op_done
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (shift/alt/ctrl codes)
//
// Write: result loaded as the word is taken. Read: through S_RD (registered RAM read).
// Clear: S_CLR zeroes one RAM row per cycle, then loads the result word.
// Sort: stable insertion sort through the single RAM port pair; per entry S_CUR
//   loads it, S_CMP shifts each larger entry up a row, then it is written in place.
// After reset a clearing pass over every row runs; no word is taken then.
// Result sits in an output register; the next word is taken no earlier than
//   the cycle in which the waiting one is accepted.
`default_nettype none
`include "key_combo_table_sorter_core_defines.svh"
module key_combo_table_sorter_core #(
  parameter int unsigned TableDepth = kcts_pkg::TableDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  kcts_in_if.sink                           in_w,
  kcts_out_if.source                        out_w,
  input  wire logic                         cfg_we_i,
  input  wire logic [kcts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [kcts_pkg::CodeW-1:0]   cfg_wdata_i
);
  localparam int unsigned AW = $clog2(TableDepth);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLR   = 6'b000010,
    S_RD    = 6'b000100,
    S_CUR   = 6'b001000,
    S_CMP   = 6'b010000,
    S_PLACE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] j_q, j_d;
  logic pend_q, pend_d;
  logic rdok_q, rdok_d;
  logic ovalid_q, ovalid_d;
  kcts_pkg::entry_t odata_q, odata_d;
  kcts_pkg::entry_t cur_q, cur_d;
  kcts_pkg::key_t curkey_q, curkey_d;
  kcts_pkg::cfg_t cfg_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  kcts_pkg::entry_t wdata, rdata, in_entry;
  kcts_pkg::key_t rkey;
  logic accept, in_range, out_load, last_i;
  logic [AW-1:0] idx_addr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{shift_code: kcts_pkg::ShiftReset, alt_code: kcts_pkg::AltReset,
                 ctrl_code: kcts_pkg::CtrlReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kcts_pkg::CFG_SHIFT: cfg_q.shift_code <= cfg_wdata_i;
        kcts_pkg::CFG_ALT:   cfg_q.alt_code   <= cfg_wdata_i;
        kcts_pkg::CFG_CTRL:  cfg_q.ctrl_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kcts_ram #(.Width(kcts_pkg::EntryW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  kcts_keygen u_key (.entry_i(rdata), .cfg_i(cfg_q), .key_o(rkey));

  assign in_entry = '{scan1: in_w.in_scan_first, scan2: in_w.in_scan_second,
                      row1: in_w.in_row_first, col1: in_w.in_col_first,
                      row2: in_w.in_row_second, col2: in_w.in_col_second};
  assign in_range = {25'd0, in_w.entry_index} < 32'(TableDepth);
  assign idx_addr = AW'(in_w.entry_index);
  assign in_w.ready = (state_q == S_IDLE) && (!ovalid_q || out_w.ready);
  assign accept = in_w.valid && in_w.ready;
  assign last_i = cnt_q == AW'(TableDepth - 1);

  // Sequencer: write, clear sweep, read, insertion sort
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    j_d      = j_q;
    pend_d   = pend_q;
    rdok_d   = rdok_q;
    cur_d    = cur_q;
    curkey_d = curkey_q;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = '0;
    raddr    = cnt_q;
    out_load = 1'b0;
    odata_d  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_w.func)
            kcts_pkg::FUNC_CLEAR: begin
              cnt_d   = '0;
              pend_d  = 1'b1;
              state_d = S_CLR;
            end
            kcts_pkg::FUNC_WRITE: begin
              we       = in_range;
              waddr    = idx_addr;
              wdata    = in_entry;
              out_load = 1'b1;
            end
            kcts_pkg::FUNC_READ: begin
              raddr   = idx_addr;
              rdok_d  = in_range;
              state_d = S_RD;
            end
            default: begin
              raddr   = AW'(1);
              cnt_d   = AW'(1);
              state_d = S_CUR;
            end
          endcase
        end
      end
      S_CLR: begin
        we = 1'b1;
        if (last_i) begin
          out_load = pend_q;
          pend_d   = 1'b0;
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_RD: begin
        out_load = 1'b1;
        odata_d  = rdok_q ? rdata : '0;
        state_d  = S_IDLE;
      end
      S_CUR: begin
        cur_d    = rdata;
        curkey_d = rkey;
        j_d      = cnt_q;
        raddr    = cnt_q - AW'(1);
        state_d  = S_CMP;
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = j_q;
        if (rkey > curkey_q) begin
          wdata = rdata;
          j_d   = j_q - AW'(1);
          if (j_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            raddr = j_q - AW'(2);
          end
        end else begin
          wdata = cur_q;
          if (last_i) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            cnt_d   = cnt_q + AW'(1);
            raddr   = cnt_q + AW'(1);
            state_d = S_CUR;
          end
        end
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = '0;
        wdata = cur_q;
        if (last_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          raddr   = cnt_q + AW'(1);
          state_d = S_CUR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ovalid_d = out_load || (ovalid_q && !out_w.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      j_q      <= '0;
      pend_q   <= 1'b0;
      rdok_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      j_q      <= j_d;
      pend_q   <= pend_d;
      rdok_q   <= rdok_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    curkey_q <= curkey_d;
    if (out_load) begin
      odata_q <= odata_d;
    end
  end

  assign out_w.valid           = ovalid_q;
  assign out_w.out_scan_first  = odata_q.scan1;
  assign out_w.out_scan_second = odata_q.scan2;
  assign out_w.out_row_first   = odata_q.row1;
  assign out_w.out_col_first   = odata_q.col1;
  assign out_w.out_row_second  = odata_q.row2;
  assign out_w.out_col_second  = odata_q.col2;
  assign out_w.op_done         = 1'b1;

  // Checks
  `KCTS_ASSERT(a_read_goes_rd,
    (accept && in_w.func == kcts_pkg::FUNC_READ) |=> state_q == S_RD,
    "read did not enter read state")
  `KCTS_ASSERT(a_j_bounded, (state_q == S_CMP) |-> (j_q <= cnt_q && j_q != '0),
    "insertion index out of range")
  `KCTS_ASSERT(a_no_overwrite, (out_load && !(state_q == S_IDLE)) |-> !ovalid_q,
    "result register overwritten")
  `KCTS_ASSERT_RST(a_reset_clears, !rst_ni |=> (state_q == S_CLR || !rst_ni),
    "reset did not start clearing pass")
endmodule
`default_nettype wire

@@ tb/tb_key_combo_table_sorter_core.sv @@
`default_nettype none
module tb_key_combo_table_sorter_core;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned CodeW      = kcts_pkg::CodeW;
  localparam int unsigned IdxW       = kcts_pkg::IdxW;
  localparam int unsigned CfgIdxW    = kcts_pkg::CfgIdxW;

  typedef struct packed {
    kcts_pkg::entry_t data;
    logic             done;
  } result_t;

  // Keeps its own copy of the table and codes; predicts each result word
  class key_table_scoreboard;
    kcts_pkg::entry_t table_q [kcts_pkg::TableDepth];
    kcts_pkg::cfg_t   codes;
    result_t          expected_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      sorts;

    function void reset_state();
      foreach (table_q[i]) table_q[i] = '0;
      codes.shift_code = kcts_pkg::ShiftReset;
      codes.alt_code   = kcts_pkg::AltReset;
      codes.ctrl_code  = kcts_pkg::CtrlReset;
    endfunction

    function void set_code(logic [CfgIdxW-1:0] idx, logic [CodeW-1:0] val);
      case (idx)
        kcts_pkg::CFG_SHIFT: codes.shift_code = val;
        kcts_pkg::CFG_ALT:   codes.alt_code   = val;
        kcts_pkg::CFG_CTRL:  codes.ctrl_code  = val;
        default: ;
      endcase
    endfunction

    function kcts_pkg::key_t order_key(kcts_pkg::entry_t e);
      kcts_pkg::key_t k;
      if (e.scan1 == '0 && e.scan2 == '0) k.cls = kcts_pkg::CLS_EMPTY;
      else if (e.scan2 != '0) k.cls = kcts_pkg::CLS_COMBO;
      else if (e.scan1 == codes.shift_code || e.scan1 == codes.alt_code ||
               e.scan1 == codes.ctrl_code) k.cls = kcts_pkg::CLS_MOD;
      else k.cls = kcts_pkg::CLS_SINGLE;
      k.scan1 = e.scan1;
      k.row1  = e.row1;
      k.col1  = e.col1;
      k.row2  = e.row2;
      k.col2  = e.col2;
      return k;
    endfunction

    // Stable insertion sort, same ordering the block must produce
    function void sort_entries();
      kcts_pkg::entry_t cur;
      kcts_pkg::key_t   ck;
      int               j;
      for (int i = 1; i < kcts_pkg::TableDepth; i++) begin
        cur = table_q[i];
        ck  = order_key(cur);
        j   = i;
        while (j > 0 && order_key(table_q[j-1]) > ck) begin
          table_q[j] = table_q[j-1];
          j--;
        end
        table_q[j] = cur;
      end
    endfunction

    // Accepted command word: update table, queue the result word
    function void note_word(logic [1:0] op, logic [IdxW-1:0] idx, kcts_pkg::entry_t e);
      result_t r;
      r.data = '0;
      r.done = 1'b1;
      case (op)
        kcts_pkg::FUNC_CLEAR: foreach (table_q[i]) table_q[i] = '0;
        kcts_pkg::FUNC_WRITE: if (idx < kcts_pkg::TableDepth) table_q[idx] = e;
        kcts_pkg::FUNC_READ:  if (idx < kcts_pkg::TableDepth) r.data = table_q[idx];
        default: begin
          sort_entries();
          sorts++;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t x;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (got.data.scan1 !== x.data.scan1) begin
        $error("out_scan_first exp %0d got %0d", x.data.scan1, got.data.scan1); errors++;
      end
      if (got.data.scan2 !== x.data.scan2) begin
        $error("out_scan_second exp %0d got %0d", x.data.scan2, got.data.scan2); errors++;
      end
      if (got.data.row1 !== x.data.row1) begin
        $error("out_row_first exp %0d got %0d", x.data.row1, got.data.row1); errors++;
      end
      if (got.data.col1 !== x.data.col1) begin
        $error("out_col_first exp %0d got %0d", x.data.col1, got.data.col1); errors++;
      end
      if (got.data.row2 !== x.data.row2) begin
        $error("out_row_second exp %0d got %0d", x.data.row2, got.data.row2); errors++;
      end
      if (got.data.col2 !== x.data.col2) begin
        $error("out_col_second exp %0d got %0d", x.data.col2, got.data.col2); errors++;
      end
      if (got.done !== x.done) begin
        $error("op_done exp %0d got %0d", x.done, got.done); errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CodeW-1:0]     cfg_wdata_i;

  kcts_in_if  in_w ();
  kcts_out_if out_w ();

  key_combo_table_sorter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w.sink),
    .out_w       (out_w.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  key_table_scoreboard sb;
  bit          no_idle;
  bit          hold_req;
  int unsigned cycle_cnt;
  int unsigned words_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted words, random backpressure, long hold-off on request
  initial begin
    int unsigned hold_cnt;
    result_t     got;
    hold_cnt = 0;
    out_w.ready <= 1'b0;
    wait (sb != null);
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_w.valid && out_w.ready) begin
        got.data.scan1 = out_w.out_scan_first;
        got.data.scan2 = out_w.out_scan_second;
        got.data.row1  = out_w.out_row_first;
        got.data.col1  = out_w.out_col_first;
        got.data.row2  = out_w.out_row_second;
        got.data.col2  = out_w.out_col_second;
        got.done       = out_w.op_done;
        sb.check_word(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= no_idle || ($urandom_range(99) >= 23);
      end
    end
  end

  // Idle cycles at random, then offer the word until it is taken
  task automatic send_word(logic [1:0] op, int unsigned idx_n, kcts_pkg::entry_t e);
    logic [IdxW-1:0] idx;
    idx = IdxW'(idx_n);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid          <= 1'b1;
    in_w.func           <= op;
    in_w.entry_index    <= idx;
    in_w.in_scan_first  <= e.scan1;
    in_w.in_scan_second <= e.scan2;
    in_w.in_row_first   <= e.row1;
    in_w.in_col_first   <= e.col1;
    in_w.in_row_second  <= e.row2;
    in_w.in_col_second  <= e.col2;
    do @(posedge clk_i); while (!in_w.ready);
    sb.note_word(op, idx, e);
    words_sent++;
  endtask

  // Drop valid and wait for every expected result word
  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_code(logic [CfgIdxW-1:0] idx, logic [CodeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_code(idx, val);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_codes(logic [CodeW-1:0] s, logic [CodeW-1:0] a, logic [CodeW-1:0] c);
    write_code(kcts_pkg::CFG_SHIFT, s);
    write_code(kcts_pkg::CFG_ALT, a);
    write_code(kcts_pkg::CFG_CTRL, c);
    @(posedge clk_i);
  endtask

  function automatic logic [CodeW-1:0] pick_field();
    case ($urandom_range(2))
      0: return CodeW'($urandom_range(3));
      1: return CodeW'($urandom_range(255));
      default: return ($urandom_range(1)) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Entries biased toward modifiers, empties and ties
  function automatic kcts_pkg::entry_t pick_entry();
    kcts_pkg::entry_t e;
    case ($urandom_range(5))
      0: e.scan1 = sb.codes.shift_code;
      1: e.scan1 = sb.codes.alt_code;
      2: e.scan1 = sb.codes.ctrl_code;
      3: e.scan1 = '0;
      4: e.scan1 = CodeW'($urandom_range(1, 4));
      default: e.scan1 = CodeW'($urandom_range(255));
    endcase
    e.scan2 = ($urandom_range(1)) ? '0 : pick_field();
    e.row1  = pick_field();
    e.col1  = pick_field();
    e.row2  = pick_field();
    e.col2  = pick_field();
    return e;
  endfunction

  task automatic random_words(int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3)       send_word(kcts_pkg::FUNC_SORT, $urandom_range(127), pick_entry());
      else if (r < 5)  send_word(kcts_pkg::FUNC_CLEAR, $urandom_range(127), pick_entry());
      else if (r < 35) send_word(kcts_pkg::FUNC_READ, $urandom_range(127), pick_entry());
      else             send_word(kcts_pkg::FUNC_WRITE, $urandom_range(127), pick_entry());
    end
  endtask

  function automatic kcts_pkg::entry_t mk(int s1, int s2, int r1, int c1, int r2, int c2);
    kcts_pkg::entry_t e;
    e.scan1 = CodeW'(s1); e.scan2 = CodeW'(s2); e.row1 = CodeW'(r1);
    e.col1  = CodeW'(c1); e.row2  = CodeW'(r2); e.col2 = CodeW'(c2);
    return e;
  endfunction

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= kcts_pkg::CFG_SHIFT;
    cfg_wdata_i <= '0;
    in_w.valid  <= 1'b0;
    in_w.func   <= kcts_pkg::FUNC_CLEAR;
    in_w.entry_index    <= '0;
    in_w.in_scan_first  <= '0;
    in_w.in_scan_second <= '0;
    in_w.in_row_first   <= '0;
    in_w.in_col_first   <= '0;
    in_w.in_row_second  <= '0;
    in_w.in_col_second  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing pass
    do @(posedge clk_i); while (!in_w.ready);

    // Directed: every op, class edges, field extremes, ties
    set_codes(kcts_pkg::ShiftReset, kcts_pkg::AltReset, kcts_pkg::CtrlReset);
    send_word(kcts_pkg::FUNC_READ, 0, '0);
    send_word(kcts_pkg::FUNC_WRITE, 127, mk(255, 255, 255, 255, 255, 255));
    send_word(kcts_pkg::FUNC_WRITE, 0, mk(0, 0, 0, 0, 0, 0));
    send_word(kcts_pkg::FUNC_WRITE, 1, mk(42, 0, 1, 1, 0, 0));
    send_word(kcts_pkg::FUNC_WRITE, 2, mk(0, 7, 3, 3, 3, 3));
    send_word(kcts_pkg::FUNC_WRITE, 3, mk(56, 0, 0, 0, 0, 0));
    send_word(kcts_pkg::FUNC_WRITE, 4, mk(29, 0, 2, 2, 2, 2));
    send_word(kcts_pkg::FUNC_WRITE, 5, mk(10, 0, 1, 1, 1, 1));
    send_word(kcts_pkg::FUNC_WRITE, 6, mk(10, 99, 1, 1, 1, 1));
    send_word(kcts_pkg::FUNC_WRITE, 7, mk(10, 5, 1, 1, 1, 1));
    send_word(kcts_pkg::FUNC_WRITE, 8, mk(10, 0, 1, 1, 1, 1));
    send_word(kcts_pkg::FUNC_READ, 127, '0);
    send_word(kcts_pkg::FUNC_READ, 6, '0);
    send_word(kcts_pkg::FUNC_SORT, 0, '0);
    for (int unsigned i = 0; i < 8; i++) send_word(kcts_pkg::FUNC_READ, i, '0);
    send_word(kcts_pkg::FUNC_READ, 127, '0);
    send_word(kcts_pkg::FUNC_CLEAR, 0, '0);
    send_word(kcts_pkg::FUNC_READ, 0, '0);
    drain();

    // Zero modifier codes: empty entries must stay empty
    set_codes(8'd0, 8'd0, 8'd0);
    random_words(170);
    drain();

    // All-ones codes, with a long receiver hold-off while words keep coming
    set_codes(8'hFF, 8'hFF, 8'hFF);
    no_idle = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 60; k++) begin
      send_word(kcts_pkg::FUNC_WRITE, $urandom_range(127), pick_entry());
    end
    no_idle = 1'b0;
    random_words(120);
    drain();

    // Random codes, long stretch with no idling on either side
    set_codes(CodeW'($urandom_range(255)), CodeW'($urandom_range(255)),
              CodeW'($urandom_range(255)));
    no_idle = 1'b1;
    random_words(170);
    no_idle = 1'b0;
    drain();

    // Small distinct codes, then back to reset values
    set_codes(8'd1, 8'd2, 8'd3);
    random_words(160);
    drain();
    set_codes(kcts_pkg::ShiftReset, kcts_pkg::AltReset, kcts_pkg::CtrlReset);
    random_words(150);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d command words, %0d result words, %0d sorts over six code settings.",
             words_sent, sb.checked, sb.sorts);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
